// ===== rtl/grid_density_normal_filter_defines.svh =====
// Assertion macros for the grid density and normal filter.
`ifndef GRID_DENSITY_NORMAL_FILTER_DEFINES_SVH
`define GRID_DENSITY_NORMAL_FILTER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, quiet during reset
`define GDNF_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset
`define GDNF_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define GDNF_ASSERT_IMP(label, ante, cons, msg)
`define GDNF_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/gdnf_pkg.sv =====
// Shared types and constants of the grid density and normal filter.
`default_nettype none

package gdnf_pkg;

	// Opcodes carried in s_tuser
	localparam logic [1:0] OP_ACCUM    = 2'd0;
	localparam logic [1:0] OP_CLASSIFY = 2'd1;
	localparam logic [1:0] OP_CLEAR    = 2'd2;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Z_ORIGIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_USED = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_USED = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_MEAN  = 3'd5;

	// Register reset values
	localparam logic [8:0]  RST_ROWS_USED = 9'd256;
	localparam logic [8:0]  RST_COLS_USED = 9'd256;
	localparam logic [15:0] RST_MIN_COUNT = 16'd40;
	localparam logic [15:0] RST_MAX_MEAN  = 16'd16384;

	// Coordinate to cell scaling: (diff * 100) >> 16
	localparam int          PROD_W   = 39;
	localparam int          FRAC_W   = 16;
	localparam int          CELL_W   = PROD_W - FRAC_W;
	localparam logic [PROD_W-1:0] CM_SCALE = 39'd100;

	// Widths of one memory entry
	localparam int CNT_W   = 16;
	localparam int SUM_W   = 32;
	localparam int ENTRY_W = CNT_W + SUM_W;

	// Controller to datapath commands
	typedef struct packed {
		logic load_in;
		logic index_en;
		logic addr_en;
		logic rd_en;
		logic mul_en;
		logic clr_en;
		logic done_en;
	} gdnf_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [1:0] op;
		logic       oog;
		logic       clr_last;
		logic       out_free;
	} gdnf_sts_t;

endpackage

`default_nettype wire

// ===== rtl/gdnf_ctrl.sv =====
// Sequencing state machine of the grid density and normal filter.
`default_nettype none

module gdnf_ctrl
	import gdnf_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	output logic           s_tready,
	input  wire gdnf_sts_t sts,
	output gdnf_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_INDEX,
		S_ADDR,
		S_READ,
		S_MULT,
		S_DONE
	} state_t;

	state_t state_q;
	logic   clr_op_q;   // sweep was asked for by a clear transaction

	// State register; the sweep after reset runs before the first transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_op_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (sts.clr_last) begin
						state_q  <= clr_op_q ? S_DONE : S_IDLE;
						clr_op_q <= 1'b0;
					end
				end
				S_IDLE: begin
					if (s_tvalid)
						state_q <= S_INDEX;
				end
				S_INDEX: begin
					case (sts.op)
						OP_CLEAR: begin
							state_q  <= S_CLEAR;
							clr_op_q <= 1'b1;
						end
						OP_ACCUM, OP_CLASSIFY: state_q <= S_ADDR;
						default:               state_q <= S_DONE;
					endcase
				end
				S_ADDR:  state_q <= S_READ;
				S_READ:  state_q <= sts.oog ? S_DONE : S_MULT;
				S_MULT:  state_q <= S_DONE;
				S_DONE: begin
					if (sts.out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Command decode
	always_comb begin
		cmd          = '0;
		cmd.load_in  = (state_q == S_IDLE) && s_tvalid;
		cmd.index_en = (state_q == S_INDEX);
		cmd.addr_en  = (state_q == S_ADDR);
		cmd.rd_en    = (state_q == S_READ) && !sts.oog;
		cmd.mul_en   = (state_q == S_MULT);
		cmd.clr_en   = (state_q == S_CLEAR);
		cmd.done_en  = (state_q == S_DONE) && sts.out_free;
	end

	assign s_tready = (state_q == S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/gdnf_dp.sv =====
// Datapath of the grid density and normal filter: registers, cell memory, arithmetic.
`default_nettype none

module gdnf_dp
	import gdnf_pkg::*;
#(
	parameter int GRID_ROWS = 256,
	parameter int GRID_COLS = 256
)
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_addr,
	input  wire logic [31:0]          cfg_data,
	input  wire logic [79:0]          s_tdata,   // y_coord, z_coord, x normal
	input  wire logic [1:0]           s_tuser,   // opcode
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [23:0]               m_tdata,   // keep, out_of_grid, cell_count, zero pad
	input  wire gdnf_cmd_t            cmd,
	output gdnf_sts_t                 sts
);

	localparam int CELLS  = GRID_ROWS * GRID_COLS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int ROW_W  = $clog2(GRID_ROWS);
	localparam int COL_W  = $clog2(GRID_COLS);

	// Configuration registers
	logic signed [31:0] y_origin_q;
	logic signed [31:0] z_origin_q;
	logic [8:0]         rows_used_q;
	logic [8:0]         cols_used_q;
	logic [15:0]        min_count_q;
	logic [15:0]        max_mean_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_origin_q  <= '0;
			z_origin_q  <= '0;
			rows_used_q <= RST_ROWS_USED;
			cols_used_q <= RST_COLS_USED;
			min_count_q <= RST_MIN_COUNT;
			max_mean_q  <= RST_MAX_MEAN;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_Y_ORIGIN:  y_origin_q  <= cfg_data;
				REG_Z_ORIGIN:  z_origin_q  <= cfg_data;
				REG_ROWS_USED: rows_used_q <= cfg_data[8:0];
				REG_COLS_USED: cols_used_q <= cfg_data[8:0];
				REG_MIN_COUNT: min_count_q <= cfg_data[15:0];
				REG_MAX_MEAN:  max_mean_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Input capture
	logic [1:0]         op_q;
	logic signed [31:0] y_q;
	logic signed [31:0] z_q;
	logic signed [15:0] nrm_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q  <= s_tuser;
			y_q   <= s_tdata[31:0];
			z_q   <= s_tdata[63:32];
			nrm_q <= s_tdata[79:64];
		end
	end

	// Stage 1: offset from origin, scaled to centimetres
	logic signed [32:0] diff_y;
	logic signed [32:0] diff_z;
	logic [PROD_W-1:0]  prod_y_s1;
	logic [PROD_W-1:0]  prod_z_s1;
	logic               neg_y_s1;
	logic               neg_z_s1;

	assign diff_y = {y_q[31], y_q} - {y_origin_q[31], y_origin_q};
	assign diff_z = {z_q[31], z_q} - {z_origin_q[31], z_origin_q};

	always_ff @(posedge clk) begin
		if (cmd.index_en) begin
			prod_y_s1 <= PROD_W'(diff_y[31:0]) * CM_SCALE;
			prod_z_s1 <= PROD_W'(diff_z[31:0]) * CM_SCALE;
			neg_y_s1  <= diff_y[32];
			neg_z_s1  <= diff_z[32];
		end
	end

	// Stage 2: grid bounds check and cell address
	logic [CELL_W-1:0] cell_y;
	logic [CELL_W-1:0] cell_z;
	logic              oog_y;
	logic              oog_z;
	logic [ADDR_W-1:0] addr_s2;
	logic              oog_s2;

	assign cell_y = prod_y_s1[PROD_W-1:FRAC_W];
	assign cell_z = prod_z_s1[PROD_W-1:FRAC_W];
	assign oog_y  = neg_y_s1 || (cell_y >= CELL_W'(rows_used_q))
	                || (cell_y >= CELL_W'(GRID_ROWS));
	assign oog_z  = neg_z_s1 || (cell_z >= CELL_W'(cols_used_q))
	                || (cell_z >= CELL_W'(GRID_COLS));

	always_ff @(posedge clk) begin
		if (cmd.addr_en) begin
			addr_s2 <= ADDR_W'(cell_y[ROW_W-1:0]) * ADDR_W'(GRID_COLS)
			           + ADDR_W'(cell_z[COL_W-1:0]);
			oog_s2  <= oog_y || oog_z;
		end
	end

	// Cell memory: count in the low bits, normal sum above
	logic [ENTRY_W-1:0] mem [CELLS];
	logic [ENTRY_W-1:0] rd_data_s3;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [ENTRY_W-1:0] wr_data;

	always_ff @(posedge clk) begin
		if (cmd.rd_en)
			rd_data_s3 <= mem[addr_s2];
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// Stage 4: mean limit scaled by the count
	logic [SUM_W-1:0] lim_s4;

	always_ff @(posedge clk) begin
		if (cmd.mul_en)
			lim_s4 <= SUM_W'(max_mean_q) * SUM_W'(rd_data_s3[CNT_W-1:0]);
	end

	// Update and classification
	logic [CNT_W-1:0] cnt;
	logic [SUM_W-1:0] sum;
	logic [15:0]      nabs;
	logic [SUM_W:0]   sum_ext;
	logic [SUM_W-1:0] new_sum;
	logic [CNT_W-1:0] new_cnt;
	logic             res_keep;
	logic             res_oog;
	logic [CNT_W-1:0] res_cnt;

	assign cnt     = rd_data_s3[CNT_W-1:0];
	assign sum     = rd_data_s3[ENTRY_W-1:CNT_W];
	assign nabs    = nrm_q[15] ? (~nrm_q + 16'd1) : nrm_q;
	assign sum_ext = {1'b0, sum} + (SUM_W+1)'(nabs);
	assign new_sum = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
	assign new_cnt = (&cnt) ? cnt : cnt + CNT_W'(1);

	always_comb begin
		res_keep = 1'b0;
		res_oog  = 1'b0;
		res_cnt  = '0;
		case (op_q)
			OP_ACCUM: begin
				res_oog = oog_s2;
				res_cnt = oog_s2 ? '0 : new_cnt;
			end
			OP_CLASSIFY: begin
				res_oog  = oog_s2;
				res_cnt  = oog_s2 ? '0 : cnt;
				res_keep = !oog_s2 && (cnt >= min_count_q) && (sum <= lim_s4);
			end
			default: ;
		endcase
	end

	// Clearing sweep
	logic [ADDR_W-1:0] sweep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sweep_q <= '0;
		else if (cmd.clr_en)
			sweep_q <= sts.clr_last ? '0 : sweep_q + ADDR_W'(1);
	end

	// Write port: sweep or accumulate update
	assign wr_en   = cmd.clr_en || (cmd.done_en && (op_q == OP_ACCUM) && !oog_s2);
	assign wr_addr = cmd.clr_en ? sweep_q : addr_s2;
	assign wr_data = cmd.clr_en ? '0 : {new_sum, new_cnt};

	// Output register
	logic             m_valid_q;
	logic             out_keep_q;
	logic             out_oog_q;
	logic [CNT_W-1:0] out_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (cmd.done_en)
			m_valid_q <= 1'b1;
		else if (m_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.done_en) begin
			out_keep_q <= res_keep;
			out_oog_q  <= res_oog;
			out_cnt_q  <= res_cnt;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, out_cnt_q, out_oog_q, out_keep_q};

	// Status
	assign sts.op       = op_q;
	assign sts.oog      = oog_s2;
	assign sts.clr_last = (sweep_q == ADDR_W'(CELLS - 1));
	assign sts.out_free = !m_valid_q || m_tready;

endmodule

`default_nettype wire

// ===== rtl/grid_density_normal_filter.sv =====
// Top level of the grid density and normal filter.
// Bins points into a GRID_ROWS x GRID_COLS grid of 1 cm cells over y and z, counts
// points and sums the absolute x normal per cell (opcode 0), keeps or drops a re-streamed
// point by its cell's count and mean normal (opcode 1), and zeroes the grid (opcode 2).
// Every input transaction gives exactly one result, one item at a time. A point inside
// the grid reaches the result register after the index, address, memory read and
// multiply stages in turn; an out-of-grid point skips the multiply, and an unused
// opcode skips the address, read and multiply stages. The next transaction is taken
// the cycle after the result is loaded; a new result waits in the last stage while the
// previous one has not left the output register. A clear zeroes the memory one cell a
// cycle and then loads its result; the same sweep runs after reset before the first
// input is accepted.
// Configuration writes are taken at any time but are meant for when the block is idle.
`default_nettype none
`include "grid_density_normal_filter_defines.svh"

module grid_density_normal_filter
	import gdnf_pkg::*;
#(
	parameter int GRID_ROWS = 256,
	parameter int GRID_COLS = 256
)
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_addr,
	input  wire logic [31:0]          cfg_data,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [79:0]          s_tdata,   // [31:0] y_coord, [63:32] z_coord, [79:64] x normal
	input  wire logic [1:0]           s_tuser,   // [1:0] opcode
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [23:0]               m_tdata    // [0] keep, [1] out_of_grid, [17:2] cell_count
);

	gdnf_cmd_t cmd;
	gdnf_sts_t sts;

	gdnf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gdnf_dp #(
		.GRID_ROWS (GRID_ROWS),
		.GRID_COLS (GRID_COLS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.sts      (sts)
	);

	// A transaction in flight blocks the next one
	`GDNF_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted while busy")
	// A result is never written over one still waiting
	`GDNF_ASSERT_IMP(a_no_overwrite, cmd.done_en, !m_tvalid || m_tready, "result overwritten")
	// Memory is read only for a cell inside the grid
	`GDNF_ASSERT_IMP(a_read_in_grid, cmd.rd_en, !sts.oog, "read of out-of-grid cell")
	// The sweep never overlaps input acceptance
	`GDNF_ASSERT_IMP(a_sweep_blocks, cmd.clr_en, !s_tready && !cmd.done_en, "sweep overlap")

endmodule

`default_nettype wire

// ===== test/grid_density_normal_filter_tb.sv =====
// Self-checking testbench for the grid density and normal filter: directed edges, then random point streams.
`default_nettype none

module grid_density_normal_filter_tb
	import gdnf_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int GRID_ROWS       = 256;
	localparam int GRID_COLS       = 256;
	localparam int WATCHDOG_CYCLES = 300000;
	localparam int DRAIN_CYCLES    = 10;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic        keep;
		logic        oog;
		logic [15:0] count;
	} point_result_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 cfg_we   = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [31:0]          cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [79:0]          s_tdata  = '0;   // [31:0] y_coord, [63:32] z_coord, [79:64] x normal
	logic [1:0]           s_tuser  = '0;   // [1:0] opcode
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [23:0]          m_tdata;         // [0] keep, [1] out_of_grid, [17:2] cell_count

	// Shadow copy of the configuration and of the grid
	logic signed [31:0] y_org     = '0;
	logic signed [31:0] z_org     = '0;
	logic [8:0]         rows_used = RST_ROWS_USED;
	logic [8:0]         cols_used = RST_COLS_USED;
	logic [15:0]        min_cnt   = RST_MIN_COUNT;
	logic [15:0]        max_mean  = RST_MAX_MEAN;
	bit [15:0]          cell_cnt[int unsigned];
	bit [31:0]          cell_sum[int unsigned];

	point_result_t pending_results[$];
	int errors      = 0;
	int quiet_count = 0;
	bit calm        = 1'b0;
	int n_acc = 0, n_cls = 0, n_kept = 0, n_oog = 0, n_clr = 0, n_other = 0;

	always #6 clk = ~clk;

	grid_density_normal_filter #(
		.GRID_ROWS(GRID_ROWS),
		.GRID_COLS(GRID_COLS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	// Effective in-use size: register capped at the grid size
	function automatic int unsigned used_limit(logic [8:0] v, int grid);
		return (int'(v) < grid) ? int'(v) : grid;
	endfunction

	// Cell index along one axis, 0 when off the grid
	function automatic bit axis_cell(logic signed [31:0] c, logic signed [31:0] org,
			int unsigned lim, output int unsigned idx);
		longint diff;
		longint scaled;
		diff = longint'(c) - longint'(org);
		idx  = 0;
		if (diff < 0)
			return 1'b0;
		scaled = (diff * 100) >>> 16;
		if (scaled >= longint'(lim))
			return 1'b0;
		idx = int'(scaled);
		return 1'b1;
	endfunction

	// Result of one point against the shadow grid; updates the grid
	function automatic point_result_t predict_point(logic [1:0] op, logic [31:0] y,
			logic [31:0] z, logic [15:0] n);
		point_result_t r;
		int unsigned row, col, addr;
		longint c, s, nabs;
		r = '0;
		if (op == OP_CLEAR) begin
			cell_cnt.delete();
			cell_sum.delete();
			n_clr++;
			return r;
		end
		if (op != OP_ACCUM && op != OP_CLASSIFY) begin
			n_other++;
			return r;
		end
		if (!axis_cell(y, y_org, used_limit(rows_used, GRID_ROWS), row) ||
				!axis_cell(z, z_org, used_limit(cols_used, GRID_COLS), col)) begin
			r.oog = 1'b1;
			n_oog++;
			return r;
		end
		addr = row * GRID_COLS + col;
		c    = cell_cnt.exists(addr) ? longint'(cell_cnt[addr]) : 0;
		s    = cell_sum.exists(addr) ? longint'(cell_sum[addr]) : 0;
		nabs = n[15] ? 65536 - longint'(n) : longint'(n);
		if (op == OP_ACCUM) begin
			if (c < 65535)
				c++;
			s = s + nabs;
			if (s > 64'sd4294967295)
				s = 64'sd4294967295;
			cell_cnt[addr] = c[15:0];
			cell_sum[addr] = s[31:0];
			r.count = c[15:0];
			n_acc++;
		end else begin
			r.keep  = !((c < longint'(min_cnt)) || (s > longint'(max_mean) * c));
			r.count = c[15:0];
			n_cls++;
			if (r.keep)
				n_kept++;
		end
		return r;
	endfunction

	// One register write, mirrored into the shadow configuration
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_Y_ORIGIN:  y_org     = data;
			REG_Z_ORIGIN:  z_org     = data;
			REG_ROWS_USED: rows_used = data[8:0];
			REG_COLS_USED: cols_used = data[8:0];
			REG_MIN_COUNT: min_cnt   = data[15:0];
			REG_MAX_MEAN:  max_mean  = data[15:0];
			default: ;
		endcase
	endtask

	task automatic set_grid(logic [31:0] yo, logic [31:0] zo, logic [8:0] rows,
			logic [8:0] cols, logic [15:0] minc, logic [15:0] maxm);
		write_reg(REG_Y_ORIGIN, yo);
		write_reg(REG_Z_ORIGIN, zo);
		write_reg(REG_ROWS_USED, {23'd0, rows});
		write_reg(REG_COLS_USED, {23'd0, cols});
		write_reg(REG_MIN_COUNT, {16'd0, minc});
		write_reg(REG_MAX_MEAN, {16'd0, maxm});
	endtask

	// Present one point and wait for its transaction; valid stays up between items unless a random gap is drawn
	task automatic send_point(logic [1:0] op, logic [31:0] y, logic [31:0] z, logic [15:0] n);
		int gap;
		gap = (!calm && $urandom_range(0, 99) < 19) ? $urandom_range(1, 3) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {n, z, y};
		do
			@(posedge clk);
		while (!s_tready);
		pending_results.insert(pending_results.size(), predict_point(op, y, z, n));
	endtask

	// Hold off until every result is back and the block has gone idle
	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Coordinate near the grid along one axis, a few just past its far edge
	function automatic logic [31:0] near_grid(logic signed [31:0] org, logic [8:0] used, int grid);
		longint span, room, top;
		span = (longint'(used_limit(used, grid)) * 65536) / 100 + 2;
		room = 64'sd2147483647 - longint'(org);
		top  = (span < room) ? span : room;
		return org + $urandom_range(0, int'(top));
	endfunction

	// Cell boundaries, both axes, and coordinates far off the grid
	task automatic test_cell_edges;
		send_point(OP_ACCUM, 32'd0, 32'd0, 16'h8000);
		send_point(OP_ACCUM, 32'd0, 32'd0, 16'h7FFF);
		send_point(OP_ACCUM, 32'd167772, 32'd167772, 16'h0000);
		send_point(OP_ACCUM, 32'd167773, 32'd0, 16'h0001);
		send_point(OP_ACCUM, 32'd0, 32'hFFFF_FFFF, 16'h0001);
		send_point(OP_ACCUM, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0005);
		send_point(OP_CLASSIFY, 32'd167117, 32'd167117, 16'h0000);
		send_point(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		send_point(OP_CLASSIFY, 32'd655, 32'd0, 16'h0000);
	endtask

	// Count threshold and mean test, including an empty cell at zero threshold
	task automatic test_classify_rules;
		drain();
		write_reg(REG_MIN_COUNT, 32'd0);
		send_point(OP_CLASSIFY, 32'd6554, 32'd0, 16'h1234);
		send_point(OP_CLASSIFY, 32'd0, 32'd0, 16'h0000);
		drain();
		write_reg(REG_MAX_MEAN, 32'd32768);
		send_point(OP_CLASSIFY, 32'd0, 32'd0, 16'h0000);
		drain();
		write_reg(REG_MAX_MEAN, 32'd0);
		send_point(OP_CLASSIFY, 32'd0, 32'd0, 16'h0000);
		send_point(OP_CLASSIFY, 32'd6554, 32'd0, 16'h0000);
		drain();
		write_reg(REG_MIN_COUNT, 32'd3);
		send_point(OP_CLASSIFY, 32'd0, 32'd0, 16'h0000);
	endtask

	// In-use rows and columns, zero size, capping above the grid, negative origin
	task automatic test_grid_limits;
		drain();
		set_grid(32'd0, 32'd0, 9'd10, 9'd1, RST_MIN_COUNT, RST_MAX_MEAN);
		send_point(OP_CLASSIFY, 32'd5899, 32'd0, 16'h0000);
		send_point(OP_CLASSIFY, 32'd6554, 32'd0, 16'h0000);
		send_point(OP_CLASSIFY, 32'd0, 32'd656, 16'h0000);
		drain();
		write_reg(REG_ROWS_USED, 32'd511);
		write_reg(REG_COLS_USED, 32'd0);
		send_point(OP_ACCUM, 32'd0, 32'd0, 16'h0100);
		drain();
		write_reg(REG_COLS_USED, 32'd511);
		write_reg(REG_Y_ORIGIN, 32'hFFFF_0000);
		send_point(OP_ACCUM, 32'hFFFF_0000, 32'd0, 16'h0100);
		send_point(OP_ACCUM, 32'hFFFE_FFFF, 32'd0, 16'h0100);
	endtask

	task automatic test_clear;
		send_point(OP_CLEAR, $urandom(), $urandom(), 16'($urandom()));
		send_point(OP_CLASSIFY, 32'hFFFF_0000, 32'd0, 16'h0000);
	endtask

	// Random stream: hot cells accumulated and re-streamed, plus fresh and junk points
	task automatic test_random_stream(int n_items, bit start_clear);
		logic [31:0] pool_y[6];
		logic [31:0] pool_z[6];
		logic [31:0] y, z;
		logic [1:0]  op;
		int r, k;
		for (int i = 0; i < 6; i++) begin
			pool_y[i] = near_grid(y_org, rows_used, GRID_ROWS);
			pool_z[i] = near_grid(z_org, cols_used, GRID_COLS);
		end
		if (start_clear)
			send_point(OP_CLEAR, $urandom(), $urandom(), 16'($urandom()));
		for (int i = 0; i < n_items; i++) begin
			r = $urandom_range(0, 99);
			k = $urandom_range(0, 5);
			if (r < 80) begin
				op = (r < 45) ? OP_ACCUM : OP_CLASSIFY;
				y  = pool_y[k];
				z  = pool_z[k];
			end else if (r < 90) begin
				op = $urandom_range(0, 1) ? OP_CLASSIFY : OP_ACCUM;
				y  = near_grid(y_org, rows_used, GRID_ROWS);
				z  = near_grid(z_org, cols_used, GRID_COLS);
			end else begin
				op = (r < 97) ? ($urandom_range(0, 1) ? OP_CLASSIFY : OP_ACCUM) : OP_UNUSED;
				y  = $urandom();
				z  = $urandom();
			end
			send_point(op, y, z, 16'($urandom()));
		end
	endtask

	// Result checking, ready stalls and the watchdog
	always @(posedge clk) begin
		point_result_t want;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_count = 0;
		else
			quiet_count++;
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with no point outstanding: %h", m_tdata);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[0] !== want.keep) begin
					$error("keep: expected %0d, got %0d", want.keep, m_tdata[0]);
					errors++;
				end
				if (m_tdata[1] !== want.oog) begin
					$error("out_of_grid: expected %0d, got %0d", want.oog, m_tdata[1]);
					errors++;
				end
				if (m_tdata[17:2] !== want.count) begin
					$error("cell_count: expected %0d, got %0d", want.count, m_tdata[17:2]);
					errors++;
				end
			end
		end
		m_tready <= calm || ($urandom_range(0, 99) >= 19);
		if (quiet_count >= WATCHDOG_CYCLES) begin
			$display("Watchdog: no transaction for %0d cycles", WATCHDOG_CYCLES);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_cell_edges();
		test_classify_rules();
		test_grid_limits();
		test_clear();

		drain();
		set_grid(32'($signed($urandom_range(0, 200000)) - 100000),
			32'($signed($urandom_range(0, 200000)) - 100000),
			9'd256, 9'd256, 16'd4, 16'd16384);
		test_random_stream(330, 1'b1);

		// Origins at the signed extremes, single cell, zero thresholds, no stalls
		drain();
		calm = 1'b1;
		set_grid(32'h8000_0000, 32'h7FFF_FFF0, 9'd1, 9'd1, 16'd0, 16'd0);
		test_random_stream(300, 1'b0);
		drain();
		calm = 1'b0;

		set_grid($urandom(), $urandom(), 9'($urandom_range(2, 255)), 9'($urandom_range(2, 255)),
			16'd12, 16'd32768);
		test_random_stream(300, 1'b1);

		drain();
		set_grid($urandom(), $urandom(), 9'd256, 9'd300, 16'd65535, 16'd65535);
		test_random_stream(250, 1'b0);

		drain();
		set_grid($urandom(), $urandom(), 9'd0, 9'd256, 16'd1, 16'd20000);
		test_random_stream(50, 1'b0);

		drain();
		$display("Run covered %0d accumulates, %0d classifies (%0d kept), %0d off-grid points,",
			n_acc, n_cls, n_kept, n_oog);
		$display("%0d grid clears and %0d unused-opcode points over six register settings",
			n_clr, n_other);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
